/* hdl/rfp_pkg.sv */
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, kind codes, status codes and instruction field helpers for
// the relocation field patcher.
// ----------------------------------------------------------------------------
package rfp_pkg;

	localparam int KIND_W   = 5;
	localparam int ARCH_W   = 2;
	localparam int ADDR_W   = 64;
	localparam int WORD_W   = 32;
	localparam int HALF_W   = 16;
	localparam int PWIDTH_W = 2;
	localparam int STATUS_W = 2;
	localparam int HI_KIND_W = 2;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// relocation kinds
	localparam logic [KIND_W-1:0] K_X86_ABS64     = 5'd0;
	localparam logic [KIND_W-1:0] K_X86_PC32      = 5'd1;
	localparam logic [KIND_W-1:0] K_X86_PLT32     = 5'd2;
	localparam logic [KIND_W-1:0] K_A64_ABS64     = 5'd3;
	localparam logic [KIND_W-1:0] K_A64_ADRP      = 5'd4;
	localparam logic [KIND_W-1:0] K_A64_ADD_LO12  = 5'd5;
	localparam logic [KIND_W-1:0] K_A64_CALL26    = 5'd6;
	localparam logic [KIND_W-1:0] K_RV_64         = 5'd7;
	localparam logic [KIND_W-1:0] K_RV_CALL       = 5'd8;
	localparam logic [KIND_W-1:0] K_RV_RELAX      = 5'd9;
	localparam logic [KIND_W-1:0] K_RV_PCREL_HI20 = 5'd10;
	localparam logic [KIND_W-1:0] K_RV_HI20       = 5'd11;
	localparam logic [KIND_W-1:0] K_RV_PCREL_LO12 = 5'd12;
	localparam logic [KIND_W-1:0] K_RV_LO12       = 5'd13;
	localparam logic [KIND_W-1:0] K_RV_CJUMP      = 5'd14;
	localparam logic [KIND_W-1:0] K_RV_JAL        = 5'd15;
	localparam logic [KIND_W-1:0] K_RV_BRANCH     = 5'd16;
	localparam logic [KIND_W-1:0] K_RV_CBRANCH    = 5'd17;
	localparam logic [KIND_W-1:0] K_OTHER         = 5'd18;

	// architectures
	localparam logic [ARCH_W-1:0] ARCH_X86  = 2'd0;
	localparam logic [ARCH_W-1:0] ARCH_A64  = 2'd1;
	localparam logic [ARCH_W-1:0] ARCH_RV   = 2'd2;
	localparam logic [ARCH_W-1:0] ARCH_NONE = 2'd3;

	// register indexes
	localparam logic [0:0] REG_TARGET_ARCH = 1'b0;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNHANDLED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_PAIR      = 2'd3;

	// store widths
	localparam logic [PWIDTH_W-1:0] PW_NONE = 2'd0;
	localparam logic [PWIDTH_W-1:0] PW_16   = 2'd1;
	localparam logic [PWIDTH_W-1:0] PW_32   = 2'd2;
	localparam logic [PWIDTH_W-1:0] PW_64   = 2'd3;

	// hi record kinds
	localparam logic [HI_KIND_W-1:0] HI_NONE  = 2'd0;
	localparam logic [HI_KIND_W-1:0] HI_PCREL = 2'd1;
	localparam logic [HI_KIND_W-1:0] HI_ABS   = 2'd2;

	// instruction masks and opcodes
	localparam logic [WORD_W-1:0] B_KEEP_MASK   = 32'h01ff_f07f;
	localparam logic [WORD_W-1:0] ADRP_IMM_MASK = 32'h60ff_ffe0;
	localparam logic [WORD_W-1:0] OPC_MASK      = 32'h0000_007f;
	localparam logic [WORD_W-1:0] JAL_OPC       = 32'h0000_006f;
	localparam logic [WORD_W-1:0] RD_RA         = 32'h0000_0080;
	localparam logic [WORD_W-1:0] NOP_WORD      = 32'h0000_0013;
	localparam logic [HALF_W-1:0] CB_KEEP_MASK  = 16'he383;
	localparam logic [HALF_W-1:0] CJ_OP_MASK    = 16'he003;
	localparam logic [HALF_W-1:0] CJ_OPC        = 16'ha001;
	localparam logic [HALF_W-1:0] CB_OP_MASK    = 16'hc003;
	localparam logic [HALF_W-1:0] CB_OPC        = 16'hc001;
	localparam logic [ADDR_W-1:0] HI_ROUND      = 64'h800;

	localparam logic [ARCH_W-1:0] ARCH_RESET = ARCH_RV;

	typedef struct packed {
		logic [KIND_W-1:0]    prev_kind;
		logic [WORD_W-1:0]    hi_offset;
		logic [HI_KIND_W-1:0] hi_kind;
	} rfp_hist_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   value;
		logic [PWIDTH_W-1:0] width;
		logic                next_word;
		logic [STATUS_W-1:0] status;
	} rfp_res_t;

	// true when v fits a signed field of n bits
	function automatic logic fits(input logic [ADDR_W-1:0] v, input int unsigned n);
		logic [ADDR_W-1:0] t;
		t = ADDR_W'($signed(v) >>> (n - 1));
		return (t == '0) || (t == '1);
	endfunction

	function automatic logic [WORD_W-1:0] swz_jal(input logic [ADDR_W-1:0] o);
		return {o[20], o[10:1], o[11], o[19:12], 12'b0};
	endfunction

	function automatic logic [HALF_W-1:0] swz_cj(input logic [ADDR_W-1:0] o);
		return {3'b0, o[11], o[4], o[9:8], o[10], o[6], o[7], o[3:1], o[5], 2'b0};
	endfunction

	function automatic logic [HALF_W-1:0] swz_cb(input logic [ADDR_W-1:0] o);
		return {3'b0, o[8], o[4:3], 3'b0, o[7:6], o[2:1], o[5], 2'b0};
	endfunction

	function automatic logic [WORD_W-1:0] swz_b(input logic [ADDR_W-1:0] o);
		return {o[12], o[10:5], 13'b0, o[4:1], o[11], 7'b0};
	endfunction

endpackage

/* hdl/rfp_regs.sv */
// ----------------------------------------------------------------------------
// rfp_regs
// APB register block holding the target architecture select.
// ----------------------------------------------------------------------------
module rfp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rfp_pkg::APB_AW-1:0]    paddr,
	input  logic [rfp_pkg::APB_DW-1:0]    pwdata,
	output logic [rfp_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output logic [rfp_pkg::ARCH_W-1:0]    target_arch
);

	logic [rfp_pkg::ARCH_W-1:0] target_arch_q;
	logic                       reg_sel;

	assign reg_sel = (paddr[2] == rfp_pkg::REG_TARGET_ARCH);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_arch_q <= rfp_pkg::ARCH_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			target_arch_q <= pwdata[rfp_pkg::ARCH_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[rfp_pkg::ARCH_W-1:0] = target_arch_q;
		end
	end

	assign target_arch = target_arch_q;

endmodule

/* hdl/rfp_calc.sv */
// ----------------------------------------------------------------------------
// rfp_calc
// Patch logic for one relocation item: offset, range checks, field
// insertion, hi/lo pairing and next state of the relocation history.
// ----------------------------------------------------------------------------
module rfp_calc (
	input  logic [rfp_pkg::ARCH_W-1:0] target_arch,
	input  logic [rfp_pkg::KIND_W-1:0] kind,
	input  logic [rfp_pkg::ADDR_W-1:0] sym,
	input  logic [rfp_pkg::ADDR_W-1:0] place,
	input  logic [rfp_pkg::WORD_W-1:0] word,
	input  rfp_pkg::rfp_hist_t         hist,
	output rfp_pkg::rfp_hist_t         hist_nxt,
	output rfp_pkg::rfp_res_t          res
);

	localparam int PG_W = rfp_pkg::ADDR_W - 12 + 1;

	logic [rfp_pkg::ADDR_W-1:0]   d;
	logic [PG_W-1:0]              pg;
	logic                         pg_fits;
	logic [rfp_pkg::ADDR_W-1:0]   off;
	logic [rfp_pkg::ADDR_W-1:0]   r;
	logic [rfp_pkg::HALF_W-1:0]   h;
	logic [rfp_pkg::ARCH_W-1:0]   arch;
	logic [rfp_pkg::STATUS_W-1:0] st;
	logic [rfp_pkg::WORD_W-1:0]   w32;

	assign d  = sym - place;
	assign pg = {1'b0, sym[rfp_pkg::ADDR_W-1:12]} - {1'b0, place[rfp_pkg::ADDR_W-1:12]};
	assign pg_fits = (pg[PG_W-1:20] == '0) || (pg[PG_W-1:20] == '1);
	assign off = (kind == rfp_pkg::K_RV_PCREL_HI20) ? d : sym;
	assign r   = off + rfp_pkg::HI_ROUND;
	assign h   = word[rfp_pkg::HALF_W-1:0];

	always_comb begin
		if (kind inside {[rfp_pkg::K_X86_ABS64 : rfp_pkg::K_X86_PLT32]}) begin
			arch = rfp_pkg::ARCH_X86;
		end else if (kind inside {[rfp_pkg::K_A64_ABS64 : rfp_pkg::K_A64_CALL26]}) begin
			arch = rfp_pkg::ARCH_A64;
		end else if (kind inside {[rfp_pkg::K_RV_64 : rfp_pkg::K_RV_CBRANCH]}) begin
			arch = rfp_pkg::ARCH_RV;
		end else begin
			arch = rfp_pkg::ARCH_NONE;
		end
	end

	always_comb begin
		res = '0;
		st  = rfp_pkg::ST_OK;
		w32 = '0;
		hist_nxt = hist;
		hist_nxt.prev_kind = kind;
		if (kind == rfp_pkg::K_OTHER || arch != target_arch) begin
			st = rfp_pkg::ST_UNHANDLED;
		end else begin
			case (kind)
				rfp_pkg::K_X86_ABS64, rfp_pkg::K_A64_ABS64, rfp_pkg::K_RV_64: begin
					res.value = sym;
					res.width = rfp_pkg::PW_64;
				end
				rfp_pkg::K_X86_PC32, rfp_pkg::K_X86_PLT32: begin
					if (!rfp_pkg::fits(d, 32)) st = rfp_pkg::ST_RANGE;
					w32 = d[31:0];
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_A64_ADRP: begin
					if (!pg_fits) st = rfp_pkg::ST_RANGE;
					w32 = (word & ~rfp_pkg::ADRP_IMM_MASK)
						| {1'b0, pg[1:0], 5'b0, pg[20:2], 5'b0};
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_A64_ADD_LO12: begin
					w32 = {word[31:22], sym[11:0], word[9:0]};
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_A64_CALL26: begin
					if (!rfp_pkg::fits(d, 28)) st = rfp_pkg::ST_RANGE;
					w32 = {word[31:26], d[27:2]};
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_RV_CALL: begin
					if (!rfp_pkg::fits(d, 21)) st = rfp_pkg::ST_RANGE;
					w32 = rfp_pkg::swz_jal(d) | rfp_pkg::RD_RA | rfp_pkg::JAL_OPC;
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_RV_RELAX: begin
					if (hist.prev_kind == rfp_pkg::K_RV_CALL) begin
						w32 = rfp_pkg::NOP_WORD;
						res.width = rfp_pkg::PW_32;
						res.next_word = 1'b1;
					end else if (!(hist.prev_kind inside
						{[rfp_pkg::K_RV_PCREL_HI20 : rfp_pkg::K_RV_LO12]})) begin
						st = rfp_pkg::ST_PAIR;
					end
				end
				rfp_pkg::K_RV_PCREL_HI20, rfp_pkg::K_RV_HI20: begin
					hist_nxt.hi_offset = off[31:0];
					hist_nxt.hi_kind = (kind == rfp_pkg::K_RV_PCREL_HI20) ?
						rfp_pkg::HI_PCREL : rfp_pkg::HI_ABS;
					if (!rfp_pkg::fits(r, 32)) st = rfp_pkg::ST_RANGE;
					w32 = {r[31:12], word[11:0]};
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_RV_PCREL_LO12, rfp_pkg::K_RV_LO12: begin
					if (hist.hi_kind != ((kind == rfp_pkg::K_RV_PCREL_LO12) ?
						rfp_pkg::HI_PCREL : rfp_pkg::HI_ABS)) begin
						st = rfp_pkg::ST_PAIR;
					end
					w32 = {hist.hi_offset[11:0], word[19:0]};
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_RV_CJUMP: begin
					if ((h & rfp_pkg::CJ_OP_MASK) != rfp_pkg::CJ_OPC) begin
						st = rfp_pkg::ST_UNHANDLED;
					end else if (!rfp_pkg::fits(d, 12)) begin
						st = rfp_pkg::ST_RANGE;
					end
					w32 = {16'b0, (h & rfp_pkg::CJ_OP_MASK) | rfp_pkg::swz_cj(d)};
					res.width = rfp_pkg::PW_16;
				end
				rfp_pkg::K_RV_JAL: begin
					if ((word & rfp_pkg::OPC_MASK) != rfp_pkg::JAL_OPC) begin
						st = rfp_pkg::ST_UNHANDLED;
					end else if (!rfp_pkg::fits(d, 21)) begin
						st = rfp_pkg::ST_RANGE;
					end
					w32 = {20'b0, word[11:0]} | rfp_pkg::swz_jal(d);
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_RV_BRANCH: begin
					if (!rfp_pkg::fits(d, 13)) st = rfp_pkg::ST_RANGE;
					w32 = (word & rfp_pkg::B_KEEP_MASK) | rfp_pkg::swz_b(d);
					res.width = rfp_pkg::PW_32;
				end
				rfp_pkg::K_RV_CBRANCH: begin
					if ((h & rfp_pkg::CB_OP_MASK) != rfp_pkg::CB_OPC) begin
						st = rfp_pkg::ST_UNHANDLED;
					end else if (!rfp_pkg::fits(d, 9)) begin
						st = rfp_pkg::ST_RANGE;
					end
					w32 = {16'b0, (h & rfp_pkg::CB_KEEP_MASK) | rfp_pkg::swz_cb(d)};
					res.width = rfp_pkg::PW_16;
				end
				default: begin
					st = rfp_pkg::ST_UNHANDLED;
				end
			endcase
			if (res.width != rfp_pkg::PW_64) begin
				res.value = {32'b0, w32};
			end
		end
		if (st != rfp_pkg::ST_OK) begin
			res.value     = '0;
			res.width     = rfp_pkg::PW_NONE;
			res.next_word = 1'b0;
		end
		res.status = st;
	end

endmodule

/* hdl/relocation_field_patcher.sv */
// ----------------------------------------------------------------------------
// relocation_field_patcher
// Applies one relocation record per cycle while results are taken and returns
// the patched value, its store width and a status; target architecture set over APB.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the result is not stalled;
// input register, patch logic, result register
// a stalled result holds while one more item waits in the input register
// reset: pipeline empty, target_arch = RISC-V 64, no previous kind, no hi record
module relocation_field_patcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rfp_pkg::APB_AW-1:0]      paddr,
	input  logic [rfp_pkg::APB_DW-1:0]      pwdata,
	output logic [rfp_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [rfp_pkg::KIND_W-1:0]      req_type,
	input  logic [rfp_pkg::ADDR_W-1:0]      sym_addr,
	input  logic [rfp_pkg::ADDR_W-1:0]      place_addr,
	input  logic [rfp_pkg::WORD_W-1:0]      orig_word,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [rfp_pkg::ADDR_W-1:0]      patch_value,
	output logic [rfp_pkg::PWIDTH_W-1:0]    patch_width,
	output logic                            patch_next_word,
	output logic [rfp_pkg::STATUS_W-1:0]    status
);

	logic [rfp_pkg::ARCH_W-1:0] target_arch;

	logic                       valid_s1;
	logic [rfp_pkg::KIND_W-1:0] kind_s1;
	logic [rfp_pkg::ADDR_W-1:0] sym_s1;
	logic [rfp_pkg::ADDR_W-1:0] place_s1;
	logic [rfp_pkg::WORD_W-1:0] word_s1;

	logic                       valid_s2;
	rfp_pkg::rfp_res_t          res_s2;

	rfp_pkg::rfp_hist_t         hist_q;
	rfp_pkg::rfp_hist_t         hist_nxt;
	rfp_pkg::rfp_res_t          res;

	logic                       adv_s2;
	logic                       fire_s1;

	rfp_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.target_arch (target_arch)
	);

	assign adv_s2    = !valid_s2 || rsp_ready;
	assign fire_s1   = valid_s1 && adv_s2;
	assign req_ready = !valid_s1 || adv_s2;

	// input register, kind codes above the list fold to other
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_s1  <= (req_type > rfp_pkg::K_OTHER) ? rfp_pkg::K_OTHER : req_type;
			sym_s1   <= sym_addr;
			place_s1 <= place_addr;
			word_s1  <= orig_word;
		end
	end

	rfp_calc u_calc (
		.target_arch (target_arch),
		.kind        (kind_s1),
		.sym         (sym_s1),
		.place       (place_s1),
		.word        (word_s1),
		.hist        (hist_q),
		.hist_nxt    (hist_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q.prev_kind <= rfp_pkg::K_OTHER;
			hist_q.hi_offset <= '0;
			hist_q.hi_kind   <= rfp_pkg::HI_NONE;
		end else if (fire_s1) begin
			hist_q <= hist_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	assign rsp_valid       = valid_s2;
	assign patch_value     = res_s2.value;
	assign patch_width     = res_s2.width;
	assign patch_next_word = res_s2.next_word;
	assign status          = res_s2.status;

endmodule

/* hdl/rfp_checker.sv */
// ----------------------------------------------------------------------------
// rfp_checker
// Port-level checks on the result channel of the relocation field patcher.
// ----------------------------------------------------------------------------
module rfp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [rfp_pkg::ADDR_W-1:0]   patch_value,
	input logic [rfp_pkg::PWIDTH_W-1:0] patch_width,
	input logic                         patch_next_word,
	input logic [rfp_pkg::STATUS_W-1:0] status
);

	// a faulted item never writes
	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != rfp_pkg::ST_OK) |->
			(patch_width == rfp_pkg::PW_NONE) && (patch_value == '0) && !patch_next_word)
		else $error("faulted item carries a write");

	// next-word store is always the 32-bit nop
	a_relax_nop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && patch_next_word |->
			(patch_width == rfp_pkg::PW_32) && (patch_value == {32'b0, rfp_pkg::NOP_WORD}))
		else $error("next-word store is not a nop");

	// value is zero-extended to the store width
	a_zero_ext: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (patch_width == rfp_pkg::PW_16 || patch_width == rfp_pkg::PW_32) |->
			(patch_value[63:32] == '0) &&
			((patch_width == rfp_pkg::PW_32) || (patch_value[31:16] == '0)))
		else $error("patch value wider than its store");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(patch_value) && $stable(patch_width) && $stable(status))
		else $error("stalled result changed");

endmodule

bind relocation_field_patcher rfp_checker u_rfp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp_valid),
	.rsp_ready       (rsp_ready),
	.patch_value     (patch_value),
	.patch_width     (patch_width),
	.patch_next_word (patch_next_word),
	.status          (status)
);

/* tb/sv/rfp_patch_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfp_patch_checker
// Watches the request, result and register ports of the relocation field
// patcher, predicts each patch from its own copy of the arch setting and
// pairing history, and compares every result in order with its prediction.
// ----------------------------------------------------------------------------
module rfp_patch_checker import rfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	input  logic                pready,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic [KIND_W-1:0]   req_type,
	input  logic [ADDR_W-1:0]   sym_addr,
	input  logic [ADDR_W-1:0]   place_addr,
	input  logic [WORD_W-1:0]   orig_word,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  logic [ADDR_W-1:0]   patch_value,
	input  logic [PWIDTH_W-1:0] patch_width,
	input  logic                patch_next_word,
	input  logic [STATUS_W-1:0] status,
	output int                  errors,
	output int                  outstanding
);

	localparam logic [APB_AW-1:0] ARCH_ADDR = APB_AW'(REG_TARGET_ARCH) << 2;
	localparam int MAX_REPORTS = 10;

	logic [ARCH_W-1:0]    arch_reg;
	logic [KIND_W-1:0]    last_kind;
	logic [WORD_W-1:0]    hi_off;
	logic [HI_KIND_W-1:0] hi_rec;
	rfp_res_t             expected_patches[$];
	rfp_res_t             want;
	rfp_res_t             got;

	function automatic logic fits_signed(input logic [ADDR_W-1:0] v, input int n);
		logic [ADDR_W-1:0] t;
		t = v + (64'd1 << (n - 1));
		return (t >> n) == '0;
	endfunction

	function automatic logic [WORD_W-1:0] jal_imm(input logic [ADDR_W-1:0] o);
		logic [WORD_W-1:0] f;
		f = '0;
		f[31] = o[20];
		f[30:21] = o[10:1];
		f[20] = o[11];
		f[19:12] = o[19:12];
		return f;
	endfunction

	function automatic logic [WORD_W-1:0] br_imm(input logic [ADDR_W-1:0] o);
		logic [WORD_W-1:0] f;
		f = '0;
		f[31] = o[12];
		f[30:25] = o[10:5];
		f[11:8] = o[4:1];
		f[7] = o[11];
		return f;
	endfunction

	function automatic logic [HALF_W-1:0] cj_imm(input logic [ADDR_W-1:0] o);
		logic [HALF_W-1:0] f;
		f = '0;
		f[12] = o[11];
		f[11] = o[4];
		f[10:9] = o[9:8];
		f[8] = o[10];
		f[7] = o[6];
		f[6] = o[7];
		f[5:3] = o[3:1];
		f[2] = o[5];
		return f;
	endfunction

	function automatic logic [HALF_W-1:0] cb_imm(input logic [ADDR_W-1:0] o);
		logic [HALF_W-1:0] f;
		f = '0;
		f[12] = o[8];
		f[11:10] = o[4:3];
		f[6:5] = o[7:6];
		f[4:3] = o[2:1];
		f[2] = o[5];
		return f;
	endfunction

	task automatic compute_patch(input logic [KIND_W-1:0] kind_in, input logic [ADDR_W-1:0] s,
			input logic [ADDR_W-1:0] p, input logic [WORD_W-1:0] w, output rfp_res_t r);
		logic [KIND_W-1:0]    k;
		logic [ARCH_W-1:0]    kind_arch;
		logic [ADDR_W-1:0]    d;
		logic [ADDR_W-1:0]    pg;
		logic [ADDR_W-1:0]    off;
		logic [ADDR_W-1:0]    rnd;
		logic [HALF_W-1:0]    h;
		logic [WORD_W-1:0]    word;
		logic [HALF_W-1:0]    half;
		logic [HI_KIND_W-1:0] need;
		k = (kind_in > K_OTHER) ? K_OTHER : kind_in;
		d = s - p;
		h = w[HALF_W-1:0];
		r = '0;
		r.status = ST_OK;
		if (k <= K_X86_PLT32)
			kind_arch = ARCH_X86;
		else if (k <= K_A64_CALL26)
			kind_arch = ARCH_A64;
		else if (k <= K_RV_CBRANCH)
			kind_arch = ARCH_RV;
		else
			kind_arch = ARCH_NONE;
		if (k == K_OTHER || kind_arch != arch_reg) begin
			r.status = ST_UNHANDLED;
		end else begin
			case (k)
				K_X86_ABS64, K_A64_ABS64, K_RV_64: begin
					r.value = s;
					r.width = PW_64;
				end
				K_X86_PC32, K_X86_PLT32: begin
					if (!fits_signed(d, 32)) begin
						r.status = ST_RANGE;
					end else begin
						r.value = {32'b0, d[31:0]};
						r.width = PW_32;
					end
				end
				K_A64_ADRP: begin
					pg = (s >> 12) - (p >> 12);
					if (!fits_signed(pg, 21)) begin
						r.status = ST_RANGE;
					end else begin
						word = w & ~ADRP_IMM_MASK;
						word[30:29] = pg[1:0];
						word[23:5] = pg[20:2];
						r.value = {32'b0, word};
						r.width = PW_32;
					end
				end
				K_A64_ADD_LO12: begin
					word = w;
					word[21:10] = s[11:0];
					r.value = {32'b0, word};
					r.width = PW_32;
				end
				K_A64_CALL26: begin
					if (!fits_signed(d, 28)) begin
						r.status = ST_RANGE;
					end else begin
						r.value = {32'b0, w[31:26], d[27:2]};
						r.width = PW_32;
					end
				end
				K_RV_CALL: begin
					if (!fits_signed(d, 21)) begin
						r.status = ST_RANGE;
					end else begin
						r.value = {32'b0, jal_imm(d) | RD_RA | JAL_OPC};
						r.width = PW_32;
					end
				end
				K_RV_RELAX: begin
					if (last_kind == K_RV_CALL) begin
						r.value = {32'b0, NOP_WORD};
						r.width = PW_32;
						r.next_word = 1'b1;
					end else if (last_kind < K_RV_PCREL_HI20 || last_kind > K_RV_LO12) begin
						r.status = ST_PAIR;
					end
				end
				K_RV_PCREL_HI20, K_RV_HI20: begin
					off = (k == K_RV_PCREL_HI20) ? d : s;
					rnd = off + HI_ROUND;
					hi_off = off[31:0];
					hi_rec = (k == K_RV_PCREL_HI20) ? HI_PCREL : HI_ABS;
					if (!fits_signed(rnd, 32)) begin
						r.status = ST_RANGE;
					end else begin
						r.value = {32'b0, rnd[31:12], w[11:0]};
						r.width = PW_32;
					end
				end
				K_RV_PCREL_LO12, K_RV_LO12: begin
					need = (k == K_RV_PCREL_LO12) ? HI_PCREL : HI_ABS;
					if (hi_rec != need) begin
						r.status = ST_PAIR;
					end else begin
						r.value = {32'b0, hi_off[11:0], w[19:0]};
						r.width = PW_32;
					end
				end
				K_RV_CJUMP: begin
					if ((h & CJ_OP_MASK) != CJ_OPC) begin
						r.status = ST_UNHANDLED;
					end else if (!fits_signed(d, 12)) begin
						r.status = ST_RANGE;
					end else begin
						half = (h & CJ_OP_MASK) | cj_imm(d);
						r.value = {48'b0, half};
						r.width = PW_16;
					end
				end
				K_RV_JAL: begin
					if ((w & OPC_MASK) != JAL_OPC) begin
						r.status = ST_UNHANDLED;
					end else if (!fits_signed(d, 21)) begin
						r.status = ST_RANGE;
					end else begin
						word = jal_imm(d);
						word[11:0] = w[11:0];
						r.value = {32'b0, word};
						r.width = PW_32;
					end
				end
				K_RV_BRANCH: begin
					if (!fits_signed(d, 13)) begin
						r.status = ST_RANGE;
					end else begin
						r.value = {32'b0, (w & B_KEEP_MASK) | br_imm(d)};
						r.width = PW_32;
					end
				end
				K_RV_CBRANCH: begin
					if ((h & CB_OP_MASK) != CB_OPC) begin
						r.status = ST_UNHANDLED;
					end else if (!fits_signed(d, 9)) begin
						r.status = ST_RANGE;
					end else begin
						half = (h & CB_KEEP_MASK) | cb_imm(d);
						r.value = {48'b0, half};
						r.width = PW_16;
					end
				end
				default: begin
				end
			endcase
		end
		last_kind = k;
		if (r.status != ST_OK) begin
			r.value = '0;
			r.width = PW_NONE;
			r.next_word = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_reg = ARCH_RESET;
			last_kind = K_OTHER;
			hi_off = '0;
			hi_rec = HI_NONE;
			expected_patches.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ARCH_ADDR)
				arch_reg = pwdata[ARCH_W-1:0];
			if (rsp_valid && rsp_ready) begin
				got.value = patch_value;
				got.width = patch_width;
				got.next_word = patch_next_word;
				got.status = status;
				if (expected_patches.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result with no item pending: value %h width %0d status %0d",
							$time, got.value, got.width, got.status);
				end else begin
					want = expected_patches.pop_front();
					if (got.value !== want.value || got.width !== want.width ||
							got.next_word !== want.next_word || got.status !== want.status) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: mismatch: expected value %h width %0d next %0b status %0d",
								$time, want.value, want.width, want.next_word, want.status);
							$display("%0t:   actual value %h width %0d next %0b status %0d",
								$time, got.value, got.width, got.next_word, got.status);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				compute_patch(req_type, sym_addr, place_addr, orig_word, want);
				expected_patches.push_back(want);
			end
			outstanding = expected_patches.size();
		end
	end

endmodule

/* tb/sv/relocation_field_patcher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relocation_field_patcher_tb
// Drives relocation records through the patcher under every arch setting:
// a directed set of range limits, opcode and pairing cases, then random
// records, some as well-formed call/relax and hi/lo sequences on RISC-V, with
// random gaps and stalls on both channels and one long result stall.
// ----------------------------------------------------------------------------
module relocation_field_patcher_tb;
	import rfp_pkg::*;

	localparam logic [APB_AW-1:0] ARCH_ADDR = APB_AW'(REG_TARGET_ARCH) << 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                req_valid;
	logic                req_ready;
	logic [KIND_W-1:0]   req_type;
	logic [ADDR_W-1:0]   sym_addr;
	logic [ADDR_W-1:0]   place_addr;
	logic [WORD_W-1:0]   orig_word;
	logic                rsp_valid;
	logic                rsp_ready;
	logic [ADDR_W-1:0]   patch_value;
	logic [PWIDTH_W-1:0] patch_width;
	logic                patch_next_word;
	logic [STATUS_W-1:0] status;

	int errors;
	int outstanding;
	int items_sent;
	int cycle_count = 0;
	bit steady;
	bit hold_off;

	relocation_field_patcher dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.sym_addr(sym_addr), .place_addr(place_addr), .orig_word(orig_word),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .patch_value(patch_value),
		.patch_width(patch_width), .patch_next_word(patch_next_word), .status(status)
	);

	rfp_patch_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.sym_addr(sym_addr), .place_addr(place_addr), .orig_word(orig_word),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .patch_value(patch_value),
		.patch_width(patch_width), .patch_next_word(patch_next_word), .status(status),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// signed offset clustered around the limits of an n-bit field
	function automatic logic [ADDR_W-1:0] near_offset(input int n);
		logic [ADDR_W-1:0] m;
		int e;
		e = $urandom_range(1, n + 1);
		case ($urandom_range(0, 11))
			0: return (64'd1 << (n - 1)) - 64'd1;
			1: return 64'd1 << (n - 1);
			2: return -(64'd1 << (n - 1));
			3: return -(64'd1 << (n - 1)) - 64'd1;
			4: return rand64();
			default: begin
				m = rand64() & ((64'd1 << e) - 64'd1);
				if ($urandom_range(0, 1))
					m = -m;
				return m;
			end
		endcase
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int n;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				n = steady ? 0 : idle_len();
				rsp_ready <= (n == 0);
				if (n > 1)
					repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] s,
			input logic [ADDR_W-1:0] p, input logic [WORD_W-1:0] w);
		int gap;
		gap = steady ? 0 : idle_len();
		if ($urandom_range(0, 63) == 0)
			steady = !steady;
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_type <= k;
		sym_addr <= s;
		place_addr <= p;
		orig_word <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_off(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] p,
			input logic [ADDR_W-1:0] d, input logic [WORD_W-1:0] w);
		send(k, p + d, p, w);
	endtask

	// one record of a given kind with content that mostly gets past the opcode checks
	task automatic send_rel(input logic [KIND_W-1:0] k);
		logic [ADDR_W-1:0] s;
		logic [ADDR_W-1:0] p;
		logic [ADDR_W-1:0] off;
		logic [WORD_W-1:0] w;
		bit good;
		p = rand64();
		w = $urandom;
		s = rand64();
		good = $urandom_range(0, 99) < 85;
		case (k)
			K_X86_PC32, K_X86_PLT32: s = p + near_offset(32);
			K_A64_ADRP: begin
				off = near_offset(21);
				s = p + (off << 12) + 64'($urandom_range(0, 4095));
			end
			K_A64_CALL26: s = p + near_offset(28);
			K_RV_CALL: s = p + near_offset(21);
			K_RV_JAL: begin
				s = p + near_offset(21);
				if (good)
					w = (w & ~OPC_MASK) | JAL_OPC;
			end
			K_RV_BRANCH: s = p + near_offset(13);
			K_RV_CJUMP: begin
				s = p + near_offset(12);
				if (good)
					w[HALF_W-1:0] = (w[HALF_W-1:0] & ~CJ_OP_MASK) | CJ_OPC;
			end
			K_RV_CBRANCH: begin
				s = p + near_offset(9);
				if (good)
					w[HALF_W-1:0] = (w[HALF_W-1:0] & ~CB_OP_MASK) | CB_OPC;
			end
			K_RV_PCREL_HI20, K_RV_HI20: begin
				off = near_offset(32);
				if ($urandom_range(0, 3) == 0)
					off = off - HI_ROUND;
				s = (k == K_RV_PCREL_HI20) ? p + off : off;
			end
			default: begin
			end
		endcase
		send(k, s, p, w);
	endtask

	task automatic send_random(input logic [ARCH_W-1:0] a);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send(KIND_W'($urandom), rand64(), rand64(), $urandom);
		end else if (a == ARCH_RV && r < 50) begin
			case ($urandom_range(0, 3))
				0: begin
					send_rel(K_RV_CALL);
					send_rel(K_RV_RELAX);
				end
				1: begin
					send_rel(K_RV_PCREL_HI20);
					send_rel(K_RV_PCREL_LO12);
					if ($urandom_range(0, 1))
						send_rel(K_RV_RELAX);
				end
				2: begin
					send_rel(K_RV_HI20);
					send_rel(K_RV_LO12);
					if ($urandom_range(0, 1))
						send_rel(K_RV_LO12);
				end
				default: begin
					send_rel(KIND_W'($urandom_range(K_RV_64, K_RV_CBRANCH)));
					case ($urandom_range(0, 2))
						0: send_rel(K_RV_RELAX);
						1: send_rel(K_RV_PCREL_LO12);
						default: send_rel(K_RV_LO12);
					endcase
				end
			endcase
		end else begin
			case (a)
				ARCH_X86: send_rel(KIND_W'($urandom_range(K_X86_ABS64, K_X86_PLT32)));
				ARCH_A64: send_rel(KIND_W'($urandom_range(K_A64_ABS64, K_A64_CALL26)));
				ARCH_RV: send_rel(KIND_W'($urandom_range(K_RV_64, K_RV_CBRANCH)));
				default: send_rel(KIND_W'($urandom_range(K_X86_ABS64, K_OTHER)));
			endcase
		end
	endtask

	task automatic run_random(input logic [ARCH_W-1:0] a, input int count, input bit with_hold);
		int target;
		int start;
		start = items_sent;
		target = items_sent + count;
		while (items_sent < target) begin
			if (with_hold && items_sent >= start + 40) begin
				hold_off = 1'b1;
				with_hold = 1'b0;
			end
			send_random(a);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (outstanding == 0);
	endtask

	task automatic set_target_arch(input logic [ARCH_W-1:0] a);
		drain();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ARCH_ADDR;
		pwdata <= APB_DW'(a);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req_type = '0;
		sym_addr = '0;
		place_addr = '0;
		orig_word = '0;
		steady = 1'b0;
		hold_off = 1'b0;
		items_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset arch is risc-v
		send(K_RV_RELAX, '0, '0, '0);
		send(K_RV_PCREL_LO12, '1, '1, '1);
		send(5'h1f, '1, '0, '1);
		send(K_OTHER, '0, '1, '0);
		send(K_X86_ABS64, '1, '1, '1);
		send(K_RV_64, '1, '0, '0);
		send_off(K_RV_CALL, 64'h1000, 64'h000f_fffe, '0);
		send(K_RV_RELAX, '1, '1, '1);
		send_off(K_RV_CALL, 64'h8000_0000_0000_0000, 64'h0010_0000, '1);
		send_off(K_RV_PCREL_HI20, '1, 64'h7fff_f7ff, '1);
		send(K_RV_PCREL_LO12, '0, '0, '0);
		send(K_RV_RELAX, '0, '0, '0);
		send(K_RV_HI20, 64'h7fff_f800, '0, '1);
		send(K_RV_PCREL_LO12, '0, '0, '0);
		send(K_RV_LO12, '0, '0, '1);
		send_off(K_RV_CJUMP, 64'h4000, 64'd2, '0);
		send_off(K_RV_CJUMP, 64'h4000, -64'd2048, {16'hffff, CJ_OPC});
		send_off(K_RV_JAL, 64'h10_0000, -64'h10_0000, JAL_OPC);
		send_off(K_RV_BRANCH, 64'h2000, 64'd4096, '1);
		send_off(K_RV_CBRANCH, 64'h2000, -64'd256, 32'hffff_fffd);
		run_random(ARCH_RV, 260, 1'b0);

		set_target_arch(ARCH_X86);
		send_off(K_X86_PC32, 64'hffff_ffff_0000_0000, -64'h8000_0000, '1);
		send_off(K_X86_PLT32, '0, 64'h8000_0000, '0);
		send(K_X86_ABS64, '0, '1, '0);
		run_random(ARCH_X86, 200, 1'b0);

		set_target_arch(ARCH_A64);
		send(K_A64_ADRP, 64'h0000_000f_ffff_f000, '0, '1);
		send(K_A64_ADRP, '0, 64'h0000_0001_0000_1000, '0);
		send(K_A64_ADD_LO12, '1, '0, '0);
		send_off(K_A64_CALL26, 64'h1000_0000, 64'h0800_0000, '1);
		send_off(K_A64_CALL26, 64'h1000_0000, -64'h0800_0000, '1);
		run_random(ARCH_A64, 220, 1'b0);

		set_target_arch(ARCH_NONE);
		run_random(ARCH_NONE, 40, 1'b0);

		set_target_arch(ARCH_RV);
		run_random(ARCH_RV, 240, 1'b1);

		drain();
		repeat (8) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
